>>> hw/rtl/msb_first_bit_packer_core_defines.svh
// assertion macros used by the bit packer core rtl
`ifndef MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MFBP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MFBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mfbp_pkg.sv
// types and constants of the msb-first bit packer
package mfbp_pkg;

    // store geometry: bytes packed big-endian into 32-bit words
    // (the byte count is a multiple of four)
    localparam int BUFFER_BYTES = 1024;
    localparam int LIMIT_BITS   = BUFFER_BYTES * 8;
    localparam int POS_W        = $clog2(LIMIT_BITS + 1);
    localparam int WORDS        = BUFFER_BYTES / 4;
    localparam int AW           = $clog2(WORDS);
    localparam int WB           = POS_W - 5;

    // request and result field widths
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 6;
    localparam int DATA_W = 32;
    localparam int OPOS_W = 14;

    // operation codes
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_EXTRACT = 2'd2,
        MODE_LOAD    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [CNT_W-1:0]   bit_len;
        logic [DATA_W-1:0]  value;
        logic [IDX_W-1:0]   byte_index;
    } t_pack_req;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        logic [OPOS_W-1:0]  write_position;
        logic [OPOS_W-1:0]  read_position;
        logic               position_precise;
        logic               overflow;
    } t_pack_rsp;

endpackage

>>> hw/rtl/msb_first_bit_packer_core.sv
// msb-first bit packer: word memory with read-modify-write sequencer
//
//  channel   signals                 direction  notes
//  request   start, busy, i_req      in         taken when start high and busy low
//  result    o_valid, o_rsp          out        one-cycle strobe, no back-pressure
//
// after acceptance busy stays high through S_RD0, S_RD1 and S_WR1: read low word, write low
// word while reading the high word, write high word; the result strobe is registered in S_WR1.
// busy is low again in the strobe cycle, so a new request can be taken then, but not while
// one is in flight; the single read port fetches the two window words in turn.
// after reset a clearing pass zeroes the store, one word per cycle, with busy high meanwhile;
// results cannot be stalled and show for exactly one cycle.
`include "msb_first_bit_packer_core_defines.svh"

module msb_first_bit_packer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mfbp_pkg::t_pack_req i_req,
    output logic                o_valid,
    output mfbp_pkg::t_pack_rsp o_rsp
);
    import mfbp_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_WR1
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_init;
    logic [POS_W-1:0]    r_wpos;
    logic [POS_W-1:0]    r_rpos;
    logic                r_precise;
    logic                r_valid;
    t_pack_rsp           r_rsp;

    // per-request working registers
    logic [CNT_W-1:0]    r_n;
    logic [DATA_W-1:0]   r_data;
    logic [AW-1:0]       r_wa;
    logic [4:0]          r_bitoff;
    logic [2:0]          r_cnt;
    logic                r_orfirst;
    logic                r_wr_en;
    logic                r_hi_ok;
    logic                r_ovf;
    logic                r_extract;
    logic [63:0]         r_ins;
    logic [63:0]         r_clr;
    logic [31:0]         r_old0;

    // word memory
    logic [31:0]         mem [WORDS];
    logic [31:0]         r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_wdata;

    // next values at acceptance
    logic [CNT_W-1:0]    n_sat;
    logic [POS_W:0]      wp_sum;
    logic [POS_W:0]      rp_sum;
    logic                app_ovf;
    logic                rd_ovf;
    logic                load_ok;
    logic [IDX_W:0]      idx_p1;
    logic [POS_W-1:0]    wp_load;
    logic [5:0]          app_end;
    logic [2:0]          app_cnt;
    logic [POS_W-1:0]    n_wpos;
    logic [POS_W-1:0]    n_rpos;
    logic                n_precise;
    logic                n_ovf;
    logic                n_wr_en;
    logic                n_extract;
    logic [WB-1:0]       n_base;
    logic [4:0]          n_bitoff;
    logic [2:0]          n_cnt;
    logic                n_orfirst;
    logic [DATA_W-1:0]   n_data;
    logic                n_hi_ok;

    // window masks
    logic [4:0]          touch5;
    logic [39:0]         touch40;
    logic [39:0]         clr40;

    // result path
    logic [AW-1:0]       wa_p1;
    logic [31:0]         hi_word;
    logic [63:0]         ext_sh;
    logic [31:0]         ext_val;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // bounds and position arithmetic for the incoming request
    always_comb begin
        n_sat   = (i_req.bit_len > CNT_W'(DATA_W)) ? CNT_W'(DATA_W) : i_req.bit_len;
        wp_sum  = {1'b0, r_wpos} + (POS_W+1)'(n_sat);
        rp_sum  = {1'b0, r_rpos} + (POS_W+1)'(n_sat);
        app_ovf = (wp_sum > (POS_W+1)'(LIMIT_BITS));
        rd_ovf  = (rp_sum > (POS_W+1)'(LIMIT_BITS));
        load_ok = (32'(i_req.byte_index) < 32'(BUFFER_BYTES));
        idx_p1  = {1'b0, i_req.byte_index} + (IDX_W+1)'(1);
        wp_load = POS_W'({idx_p1, 3'b000});
        // bytes written by an append, incl. the zero byte after a filled partial byte
        app_end = 6'(r_wpos[2:0]) + n_sat;
        if ((r_wpos[2:0] != 3'd0) && (app_end <= 6'd8)) begin
            app_cnt = 3'd2;
        end else begin
            app_cnt = 3'((app_end + 6'd7) >> 3);
        end
    end

    // operation decode
    always_comb begin
        n_wpos    = r_wpos;
        n_rpos    = r_rpos;
        n_precise = r_precise;
        n_ovf     = 1'b0;
        n_wr_en   = 1'b0;
        n_extract = 1'b0;
        n_base    = '0;
        n_bitoff  = '0;
        n_cnt     = 3'd1;
        n_orfirst = 1'b0;
        n_data    = '0;
        case (i_req.mode)
            MODE_CLEAR: begin
                n_wpos    = '0;
                n_rpos    = '0;
                n_precise = 1'b1;
                n_wr_en   = 1'b1;
            end
            MODE_APPEND: begin
                n_base    = r_wpos[POS_W-1:5];
                n_bitoff  = r_wpos[4:0];
                n_data    = i_req.value << (6'd32 - n_sat);
                n_cnt     = app_cnt;
                n_orfirst = (r_wpos[2:0] != 3'd0);
                if (n_sat != '0) begin
                    if (app_ovf) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_wpos  = wp_sum[POS_W-1:0];
                        n_wr_en = 1'b1;
                    end
                end
            end
            MODE_EXTRACT: begin
                n_base   = r_rpos[POS_W-1:5];
                n_bitoff = r_rpos[4:0];
                if (n_sat != '0) begin
                    if (rd_ovf) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_rpos    = rp_sum[POS_W-1:0];
                        n_extract = 1'b1;
                    end
                end
            end
            MODE_LOAD: begin
                if (load_ok) begin
                    n_base    = WB'(i_req.byte_index[IDX_W-1:2]);
                    n_bitoff  = {i_req.byte_index[1:0], 3'b000};
                    n_data    = {i_req.value[7:0], 24'd0};
                    n_wpos    = wp_load;
                    n_precise = 1'b0;
                    n_wr_en   = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            default: begin
                n_ovf = 1'b0;
            end
        endcase
        n_hi_ok = (({1'b0, n_base} + (WB+1)'(1)) < (WB+1)'(WORDS));
    end

    // byte masks of the five-byte window, first byte on top
    always_comb begin
        touch5 = ~(5'b11111 >> r_cnt);
        for (int k = 0; k < 5; k++) begin
            touch40[8*k +: 8] = {8{touch5[k]}};
        end
        clr40 = touch40 & ~(r_orfirst ? 40'hFF_0000_0000 : 40'd0);
    end

    // memory port control
    always_comb begin
        wa_p1     = r_wa + AW'(1);
        hi_word   = r_hi_ok ? r_rdata : 32'd0;
        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_raddr = r_wa;
        mem_wdata = '0;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_init;
            end
            S_RD1: begin
                mem_raddr = wa_p1;
                mem_we    = r_wr_en;
                mem_wdata = (r_rdata & ~r_clr[63:32]) | r_ins[63:32];
            end
            S_WR1: begin
                mem_waddr = wa_p1;
                mem_we    = r_wr_en && r_hi_ok;
                mem_wdata = (hi_word & ~r_clr[31:0]) | r_ins[31:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // extracted bits, right aligned
    always_comb begin
        ext_sh  = {r_old0, hi_word} << r_bitoff;
        ext_val = r_extract ? (ext_sh[63:32] >> (6'd32 - r_n)) : 32'd0;
    end

    // store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_init    <= '0;
            r_wpos    <= '0;
            r_rpos    <= '0;
            r_precise <= 1'b1;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + AW'(1);
                    if (r_init == AW'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_wpos    <= n_wpos;
                        r_rpos    <= n_rpos;
                        r_precise <= n_precise;
                        r_n       <= n_sat;
                        r_data    <= n_data;
                        r_wa      <= AW'(n_base);
                        r_bitoff  <= n_bitoff;
                        r_cnt     <= n_cnt;
                        r_orfirst <= n_orfirst;
                        r_wr_en   <= n_wr_en;
                        r_hi_ok   <= n_hi_ok;
                        r_ovf     <= n_ovf;
                        r_extract <= n_extract;
                        r_state   <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_ins   <= {r_data, 32'd0} >> r_bitoff;
                    r_clr   <= {clr40, 24'd0} >> {r_bitoff[4:3], 3'b000};
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_old0  <= r_rdata;
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_valid                <= 1'b1;
                    r_rsp.read_value       <= ext_val;
                    r_rsp.write_position   <= OPOS_W'(r_wpos);
                    r_rsp.read_position    <= OPOS_W'(r_rpos);
                    r_rsp.position_precise <= r_precise;
                    r_rsp.overflow         <= r_ovf;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `MFBP_ASSERT_NEXT(a_result_after_write, r_state == S_WR1, o_valid, "result strobe missing")
    `MFBP_ASSERT_IMPLIES(a_write_phase, mem_we, busy && (r_state != S_RD0), "write while idle")
    `MFBP_ASSERT_IMPLIES(a_wpos_range, 1'b1, r_wpos <= POS_W'(LIMIT_BITS), "wpos past end")
    `MFBP_ASSERT_IMPLIES(a_rpos_range, 1'b1, r_rpos <= POS_W'(LIMIT_BITS), "rpos past end")
    `MFBP_ASSERT_IMPLIES(a_ovf_zero, r_valid && r_ovf, o_rsp.read_value == '0, "data on ovf")

endmodule
